// ----- hw/rtl/sorted_priority_queue_core_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue core
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define SPQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted priority queue: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define SPQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted priority queue: next-cycle check failed");

`endif

// ----- hw/rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Types and constants shared by the sorted priority queue cells, core and
// checker.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Number of cells in the chain
  localparam int DEPTH   = 16;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int COUNT_W = 5;

  // Count field value reported on a full queue
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Input word
  typedef struct packed {
    cmd_t               cmd;
    logic signed [31:0] data_in;
    logic [7:0]         priority_in;
  } req_t;

  // Result word
  typedef struct packed {
    status_t            status;
    logic signed [31:0] out_data;
    logic [7:0]         out_priority;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  // One stored entry
  typedef struct packed {
    logic signed [31:0] data;
    logic [7:0]         key;
  } entry_t;

  // Per-cell control from the core
  typedef struct packed {
    logic enq;       // an enqueue is being applied this cycle
    logic occupied;  // this cell holds a live entry
    logic at_fill;   // this cell is the first free slot
    logic left_gt;   // left neighbor is shifting right
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry, compares it with the new key
// and on enqueue either keeps it, takes the left neighbor's entry, or takes
// the new entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  spq_pkg::entry_t     new_entry,
  input  spq_pkg::entry_t     left_entry,
  output spq_pkg::entry_t     entry,
  output logic                gt
);

  // Strictly greater key: the new entry lands before this one
  assign gt = ctrl.occupied && (entry.key > new_entry.key);

  // Shift right, insert or hold
  always_ff @(posedge clk) begin
    if (ctrl.enq) begin
      if (ctrl.left_gt) begin
        entry <= left_entry;
      end else if (gt || ctrl.at_fill) begin
        entry <= new_entry;
      end
    end
  end

endmodule

// ----- hw/rtl/sorted_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Sorted priority queue built as a chain of compare-and-shift cells.
//
//   channel  | ports                  | handshake
//   ---------+------------------------+-----------------------------------
//   request  | req (req_t)            | taken when start && !busy
//   result   | rsp (rsp_t)            | rsp_valid high for one cycle
//
// One word per cycle: every cell compares its key against the new key in
// parallel and shifts or inserts in the same edge, so busy stays low.
// The result is registered and appears in the cycle after the request is taken.
// Reset clears the fill count and rsp_valid only; cell contents are stale until written.
// The receiver cannot stall; a result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::req_t req,
  output logic          rsp_valid,
  output spq_pkg::rsp_t rsp
);

  logic                        accept;
  logic                        full;
  logic                        empty;
  logic                        do_enq;
  logic [spq_pkg::CNT_W-1:0]   fill;
  logic [spq_pkg::CNT_W-1:0]   fill_next;
  logic [spq_pkg::CNT_W-1:0]   fill_m1;
  logic [spq_pkg::IDX_W-1:0]   tail_idx;
  spq_pkg::entry_t             new_entry;
  spq_pkg::entry_t             entries [spq_pkg::DEPTH];
  logic [spq_pkg::DEPTH-1:0]   gt;
  spq_pkg::rsp_t               rsp_next;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign full      = (fill == spq_pkg::CNT_W'(spq_pkg::DEPTH));
  assign empty     = (fill == '0);
  assign do_enq    = accept && (req.cmd == spq_pkg::CMD_ENQ) && !full;
  assign new_entry = '{data: req.data_in, key: req.priority_in};
  assign fill_m1   = fill - spq_pkg::CNT_W'(1);
  assign tail_idx  = fill_m1[spq_pkg::IDX_W-1:0];

  // Cell chain
  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    spq_pkg::cell_ctrl_t ctrl;
    spq_pkg::entry_t     left_entry;

    if (i == 0) begin : g_head
      assign left_entry = new_entry;
      assign ctrl.left_gt = 1'b0;
    end else begin : g_body
      assign left_entry = entries[i-1];
      assign ctrl.left_gt = gt[i-1];
    end

    assign ctrl.enq      = do_enq;
    assign ctrl.occupied = (spq_pkg::CNT_W'(i) < fill);
    assign ctrl.at_fill  = (spq_pkg::CNT_W'(i) == fill);

    spq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .new_entry  (new_entry),
      .left_entry (left_entry),
      .entry      (entries[i]),
      .gt         (gt[i])
    );
  end

  // Fill count and result word
  always_comb begin
    fill_next = fill;
    rsp_next  = '0;
    rsp_next.status = spq_pkg::ST_OK;
    if (req.cmd == spq_pkg::CMD_ENQ) begin
      if (full) begin
        rsp_next.status = spq_pkg::ST_FULL;
      end else begin
        fill_next = fill + spq_pkg::CNT_W'(1);
      end
    end else begin
      if (empty) begin
        rsp_next.status = spq_pkg::ST_EMPTY;
      end else begin
        fill_next             = fill_m1;
        rsp_next.out_data     = entries[tail_idx].data;
        rsp_next.out_priority = entries[tail_idx].key;
      end
    end
    rsp_next.count = spq_pkg::COUNT_W'(fill_next);
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= accept;
      if (accept) begin
        fill <= fill_next;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ----- hw/rtl/spq_checker.sv -----
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue core, bound to the top.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_core_macros.svh"

module spq_checker (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input spq_pkg::req_t req,
  input logic          rsp_valid,
  input spq_pkg::rsp_t rsp
);

  // Every taken word yields one result the next cycle, and only then
  `SPQ_ASSERT_NEXT(a_rsp_follows, start && !busy, rsp_valid)
  `SPQ_ASSERT_NEXT(a_no_spurious, !(start && !busy), !rsp_valid)

  // Empty dequeue reports nothing held and no data
  `SPQ_ASSERT_NOW(a_empty_rsp, rsp_valid && rsp.status == spq_pkg::ST_EMPTY,
    rsp.count == '0 && rsp.out_data == '0 && rsp.out_priority == '0)

  // Full refusal reports a full count
  `SPQ_ASSERT_NOW(a_full_rsp, rsp_valid && rsp.status == spq_pkg::ST_FULL,
    rsp.count == spq_pkg::FULL_COUNT)

  // Good enqueue returns no data and a nonzero count
  `SPQ_ASSERT_NOW(a_enq_rsp,
    rsp_valid && rsp.status == spq_pkg::ST_OK && $past(req.cmd) == spq_pkg::CMD_ENQ,
    rsp.out_data == '0 && rsp.out_priority == '0 && rsp.count != '0)

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (.*);
